/* design/gwp_pkg.sv */
// Shared types and constants of the grid wavefront path planner.
// Used by gwp_ctrl, gwp_datapath and grid_wavefront_path_planner_core.
package gwp_pkg;

    localparam int GRID_SIZE_DEF = 6;
    localparam int MAX_MOVES_DEF = 64;

    localparam int COORD_W    = 3;
    localparam int DIR_W      = 2;
    localparam int STAT_W     = 2;
    localparam int SWEEP_W    = 8;
    localparam int WAVE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;

    localparam logic [COORD_W-1:0] GOAL_ROW_RST    = 3'd0;
    localparam logic [COORD_W-1:0] GOAL_COL_RST    = 3'd3;
    localparam logic [SWEEP_W-1:0] SWEEP_LIMIT_RST = 8'd50;

    localparam logic [WAVE_W-1:0] WAVE_WALL  = 8'd255;
    localparam logic [WAVE_W-1:0] WAVE_ROBOT = 8'd254;
    localparam logic [WAVE_W-1:0] WAVE_LIMIT = 8'd250;
    localparam logic [WAVE_W-1:0] WAVE_GOAL  = 8'd1;

    typedef enum logic [DIR_W-1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef enum logic [STAT_W-1:0] {
        ST_MOVED   = 2'd0,
        ST_ARRIVED = 2'd1,
        ST_NO_PATH = 2'd2,
        ST_REJECT  = 2'd3
    } t_status;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_PLAN  = 1'b1
    } t_cmd_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_ROW    = 2'd0,
        CFG_GOAL_COL    = 2'd1,
        CFG_SWEEP_LIMIT = 2'd2
    } t_cfg_reg;

    // Wave map read selection relative to the current cell
    typedef enum logic [2:0] {
        RD_SELF  = 3'd0,
        RD_DOWN  = 3'd1,
        RD_UP    = 3'd2,
        RD_RIGHT = 3'd3,
        RD_LEFT  = 3'd4
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_WCLR,
        S_IDLE,
        S_CHK,
        S_DEC,
        S_START,
        S_IRD,
        S_IWR,
        S_RSELF,
        S_RDN,
        S_RUP,
        S_RRT,
        S_RLT,
        S_UPD,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    cnt_clr;
        logic    cnt_step;
        logic    wall_clr;
        logic    wall_rd_tgt;
        logic    set_robot;
        logic    moves_clr;
        logic    moves_step;
        logic    move;
        logic    sweep_clr;
        logic    sweep_step;
        logic    best_init;
        logic    cap_self;
        t_rd_sel rd_sel;
        logic    nbr_cmp;
        t_dir    nbr_dir;
        logic    wave_init;
        logic    wave_upd;
        logic    res_set;
        t_status res_stat;
        logic    res_moved;
        logic    res_last;
        logic    out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_plan;
        logic cnt_last;
        logic start_bad;
        logic goal_out;
        logic at_goal;
        logic sweep_zero;
        logic sweep_last;
        logic self_skip;
        logic self_robot;
        logic best_ok;
        logic best_set;
        logic move_goal;
        logic move_cap;
        logic out_free;
        logic res_last;
    } t_dp_stat;

endpackage

/* design/gwp_ctrl.sv */
// Sequencer of the planner: map clear, start checks, wave rebuild, sweeps, result hand-off.
// Depends on gwp_pkg; drives gwp_datapath through t_ctl_cmd and reads t_dp_stat.
module gwp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  gwp_pkg::t_dp_stat i_stat,
    output gwp_pkg::t_ctl_cmd o_cmd
);
    import gwp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WCLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_WCLR: begin
                if (i_stat.cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid && i_stat.in_plan) n_state = S_CHK;
            end
            S_CHK:   n_state = S_DEC;
            S_DEC:   n_state = i_stat.start_bad ? S_EMIT : S_START;
            S_START: begin
                n_state = (i_stat.goal_out || i_stat.at_goal) ? S_EMIT : S_IRD;
            end
            S_IRD:   n_state = S_IWR;
            S_IWR: begin
                if (i_stat.cnt_last) n_state = i_stat.sweep_zero ? S_EMIT : S_RSELF;
                else                 n_state = S_IRD;
            end
            S_RSELF: n_state = S_RDN;
            S_RDN: begin
                if (!i_stat.self_skip)                        n_state = S_RUP;
                else if (i_stat.cnt_last && i_stat.sweep_last) n_state = S_EMIT;
                else                                          n_state = S_RSELF;
            end
            S_RUP:   n_state = S_RRT;
            S_RRT:   n_state = S_RLT;
            S_RLT:   n_state = S_UPD;
            S_UPD:   n_state = S_FIN;
            S_FIN: begin
                if (i_stat.self_robot && i_stat.best_ok)      n_state = S_EMIT;
                else if (i_stat.cnt_last && i_stat.sweep_last) n_state = S_EMIT;
                else                                          n_state = S_RSELF;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = i_stat.res_last ? S_IDLE : S_IRD;
            end
            default: n_state = S_WCLR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_WCLR: begin
                o_cmd.wall_clr = 1'b1;
                o_cmd.cnt_step = 1'b1;
            end
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_CHK: begin
                o_cmd.wall_rd_tgt = 1'b1;
            end
            S_DEC: begin
                if (i_stat.start_bad) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_stat = ST_REJECT;
                    o_cmd.res_last = 1'b1;
                end else begin
                    o_cmd.set_robot = 1'b1;
                end
            end
            S_START: begin
                o_cmd.cnt_clr   = 1'b1;
                o_cmd.moves_clr = 1'b1;
                if (i_stat.goal_out) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_stat = ST_NO_PATH;
                    o_cmd.res_last = 1'b1;
                end else if (i_stat.at_goal) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_stat = ST_ARRIVED;
                    o_cmd.res_last = 1'b1;
                end
            end
            S_IWR: begin
                o_cmd.wave_init = 1'b1;
                o_cmd.cnt_step  = 1'b1;
                if (i_stat.cnt_last) begin
                    o_cmd.sweep_clr = 1'b1;
                    if (i_stat.sweep_zero) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_stat = ST_NO_PATH;
                        o_cmd.res_last = 1'b1;
                    end
                end
            end
            S_RSELF: begin
                o_cmd.rd_sel    = RD_SELF;
                o_cmd.best_init = 1'b1;
            end
            S_RDN: begin
                o_cmd.cap_self = 1'b1;
                o_cmd.rd_sel   = RD_DOWN;
                // walls and the goal keep their value: skip to the next cell
                if (i_stat.self_skip) begin
                    o_cmd.cnt_step = 1'b1;
                    if (i_stat.cnt_last) begin
                        o_cmd.sweep_step = 1'b1;
                        if (i_stat.sweep_last) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_stat = ST_NO_PATH;
                            o_cmd.res_last = 1'b1;
                        end
                    end
                end
            end
            S_RUP: begin
                o_cmd.nbr_cmp = 1'b1;
                o_cmd.nbr_dir = DIR_DOWN;
                o_cmd.rd_sel  = RD_UP;
            end
            S_RRT: begin
                o_cmd.nbr_cmp = 1'b1;
                o_cmd.nbr_dir = DIR_UP;
                o_cmd.rd_sel  = RD_RIGHT;
            end
            S_RLT: begin
                o_cmd.nbr_cmp = 1'b1;
                o_cmd.nbr_dir = DIR_RIGHT;
                o_cmd.rd_sel  = RD_LEFT;
            end
            S_UPD: begin
                o_cmd.nbr_cmp = 1'b1;
                o_cmd.nbr_dir = DIR_LEFT;
            end
            S_FIN: begin
                if (i_stat.self_robot && i_stat.best_ok) begin
                    o_cmd.move       = 1'b1;
                    o_cmd.moves_step = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_moved  = 1'b1;
                    if (i_stat.move_goal)     o_cmd.res_stat = ST_ARRIVED;
                    else if (i_stat.move_cap) o_cmd.res_stat = ST_REJECT;
                    else                      o_cmd.res_stat = ST_MOVED;
                    o_cmd.res_last = i_stat.move_goal || i_stat.move_cap;
                end else begin
                    o_cmd.wave_upd = !i_stat.self_robot && i_stat.best_set;
                    o_cmd.cnt_step = 1'b1;
                    if (i_stat.cnt_last) begin
                        o_cmd.sweep_step = 1'b1;
                        if (i_stat.sweep_last) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_stat = ST_NO_PATH;
                            o_cmd.res_last = 1'b1;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.cnt_clr  = !i_stat.res_last;
                end
            end
            default: ;
        endcase
    end

endmodule

/* design/gwp_datapath.sv */
// Datapath of the planner: wall map and wave map memories, cell counters, neighbor
// compare, robot position, configuration registers and the result register.
// Depends on gwp_pkg; commanded by gwp_ctrl.
module gwp_datapath #(
    parameter int GRID_SIZE = gwp_pkg::GRID_SIZE_DEF,
    parameter int MAX_MOVES = gwp_pkg::MAX_MOVES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [gwp_pkg::S_DATA_W-1:0]      i_s_tdata,
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [gwp_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gwp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gwp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  gwp_pkg::t_ctl_cmd                 i_cmd,
    output gwp_pkg::t_dp_stat                 o_stat
);
    import gwp_pkg::*;

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int CW    = $clog2(CELLS);
    localparam int PW    = ($clog2(GRID_SIZE) > COORD_W) ? $clog2(GRID_SIZE) : COORD_W;
    localparam int MW    = $clog2(MAX_MOVES);
    localparam logic [PW-1:0] LAST_RC   = PW'(GRID_SIZE - 1);
    localparam logic [MW-1:0] LAST_MOVE = MW'(MAX_MOVES - 1);

    function automatic logic [CW-1:0] f_idx(input logic [PW-1:0] row,
                                            input logic [PW-1:0] col);
        int t;
        t = int'(row) * GRID_SIZE + int'(col);
        return t[CW-1:0];
    endfunction

    // input beat fields
    logic [PW-1:0] in_row;
    logic [PW-1:0] in_col;
    logic          in_wall;
    logic          in_ok;
    logic [CW-1:0] in_idx;

    assign in_row  = PW'(i_s_tdata[COORD_W-1:0]);
    assign in_col  = PW'(i_s_tdata[2*COORD_W-1:COORD_W]);
    assign in_wall = i_s_tdata[2*COORD_W];
    assign in_ok   = (in_row <= LAST_RC) && (in_col <= LAST_RC);
    assign in_idx  = f_idx(in_row, in_col);

    logic [PW-1:0]      r_row, r_col;
    logic [PW-1:0]      r_tgt_row, r_tgt_col;
    logic               r_tgt_ok;
    logic [PW-1:0]      r_robot_row, r_robot_col;
    logic [COORD_W-1:0] r_goal_row, r_goal_col;
    logic [SWEEP_W-1:0] r_limit;
    logic [SWEEP_W-1:0] r_sweep;
    logic [MW-1:0]      r_moves;
    logic [WAVE_W-1:0]  r_self;
    logic [WAVE_W-1:0]  r_best;
    t_dir               r_best_dir;
    logic               r_wall_mem [CELLS];
    logic               r_wall_rd;
    logic [WAVE_W-1:0]  r_wave_mem [CELLS];
    logic [WAVE_W-1:0]  r_wave_rd;
    t_dir               r_res_dir;
    t_status            r_res_stat;
    logic               r_res_last;
    logic               r_out_valid;
    t_dir               r_out_dir;
    t_status            r_out_stat;
    logic [COORD_W-1:0] r_out_row, r_out_col;
    logic               r_out_last;

    logic [CW-1:0]      cur_idx;
    logic [CW-1:0]      robot_idx;
    logic [CW-1:0]      goal_idx;
    logic [PW-1:0]      goal_row_x, goal_col_x;
    logic [CW-1:0]      wave_addr;
    logic [CW-1:0]      wall_waddr;
    logic [CW-1:0]      wall_raddr;
    logic               wall_we;
    logic               wall_wdata;
    logic               wave_we;
    logic [WAVE_W-1:0]  wave_wdata;
    logic [WAVE_W-1:0]  init_val;
    logic               nbr_ok;
    logic               nbr_hit;
    logic [PW-1:0]      nxt_row, nxt_col;

    assign cur_idx    = f_idx(r_row, r_col);
    assign robot_idx  = f_idx(r_robot_row, r_robot_col);
    assign goal_row_x = PW'(r_goal_row);
    assign goal_col_x = PW'(r_goal_col);
    assign goal_idx   = f_idx(goal_row_x, goal_col_x);

    // cell counter in raster order, wraps after the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.cnt_step) begin
            if (r_col == LAST_RC) begin
                r_col <= '0;
                r_row <= (r_row == LAST_RC) ? '0 : r_row + PW'(1);
            end else begin
                r_col <= r_col + PW'(1);
            end
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_row <= GOAL_ROW_RST;
            r_goal_col <= GOAL_COL_RST;
            r_limit    <= SWEEP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GOAL_ROW:    r_goal_row <= i_cfg_data[COORD_W-1:0];
                CFG_GOAL_COL:    r_goal_col <= i_cfg_data[COORD_W-1:0];
                CFG_SWEEP_LIMIT: r_limit    <= i_cfg_data[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // plan target, robot position, counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tgt_row <= in_row;
            r_tgt_col <= in_col;
            r_tgt_ok  <= in_ok;
        end
    end

    always_comb begin
        nxt_row = r_robot_row;
        nxt_col = r_robot_col;
        case (r_best_dir)
            DIR_UP:    nxt_row = r_robot_row - PW'(1);
            DIR_RIGHT: nxt_col = r_robot_col + PW'(1);
            DIR_DOWN:  nxt_row = r_robot_row + PW'(1);
            DIR_LEFT:  nxt_col = r_robot_col - PW'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_row <= '0;
            r_robot_col <= '0;
            r_sweep     <= '0;
            r_moves     <= '0;
        end else begin
            if (i_cmd.set_robot) begin
                r_robot_row <= r_tgt_row;
                r_robot_col <= r_tgt_col;
            end else if (i_cmd.move) begin
                r_robot_row <= nxt_row;
                r_robot_col <= nxt_col;
            end
            if (i_cmd.sweep_clr)       r_sweep <= '0;
            else if (i_cmd.sweep_step) r_sweep <= r_sweep + SWEEP_W'(1);
            if (i_cmd.moves_clr)       r_moves <= '0;
            else if (i_cmd.moves_step) r_moves <= r_moves + MW'(1);
        end
    end

    // wall map
    assign wall_we    = i_cmd.wall_clr || (i_cmd.accept && (i_s_tuser == CMD_WRITE) && in_ok);
    assign wall_waddr = i_cmd.wall_clr ? cur_idx : in_idx;
    assign wall_wdata = i_cmd.wall_clr ? 1'b0 : in_wall;
    assign wall_raddr = i_cmd.wall_rd_tgt ?
                        (r_tgt_ok ? f_idx(r_tgt_row, r_tgt_col) : '0) : cur_idx;

    always_ff @(posedge i_clk) begin
        if (wall_we) r_wall_mem[wall_waddr] <= wall_wdata;
        r_wall_rd <= r_wall_mem[wall_raddr];
    end

    // wave map: one read and one write a cycle
    always_comb begin : p_wave_addr
        int t;
        t = int'(cur_idx);
        case (i_cmd.rd_sel)
            RD_DOWN:  if (r_row != LAST_RC) t = t + GRID_SIZE;
            RD_UP:    if (r_row != '0)      t = t - GRID_SIZE;
            RD_RIGHT: if (r_col != LAST_RC) t = t + 1;
            RD_LEFT:  if (r_col != '0)      t = t - 1;
            default: ;
        endcase
        wave_addr = t[CW-1:0];
    end

    always_comb begin
        if (cur_idx == robot_idx)     init_val = WAVE_ROBOT;
        else if (cur_idx == goal_idx) init_val = WAVE_GOAL;
        else if (r_wall_rd)           init_val = WAVE_WALL;
        else                          init_val = '0;
    end

    assign wave_we    = i_cmd.wave_init || i_cmd.wave_upd;
    assign wave_wdata = i_cmd.wave_init ? init_val : r_best + WAVE_W'(1);

    always_ff @(posedge i_clk) begin
        if (wave_we) r_wave_mem[cur_idx] <= wave_wdata;
        r_wave_rd <= r_wave_mem[wave_addr];
    end

    // neighbor minimum, first hit wins on ties
    always_comb begin
        case (i_cmd.nbr_dir)
            DIR_DOWN:  nbr_ok = (r_row != LAST_RC);
            DIR_UP:    nbr_ok = (r_row != '0);
            DIR_RIGHT: nbr_ok = (r_col != LAST_RC);
            DIR_LEFT:  nbr_ok = (r_col != '0);
            default:   nbr_ok = 1'b0;
        endcase
    end

    assign nbr_hit = nbr_ok && (r_wave_rd != '0) && (r_wave_rd < r_best);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_self) r_self <= r_wave_rd;
        if (i_cmd.best_init) begin
            r_best     <= WAVE_LIMIT;
            r_best_dir <= DIR_UP;
        end else if (i_cmd.nbr_cmp && nbr_hit) begin
            r_best     <= r_wave_rd;
            r_best_dir <= i_cmd.nbr_dir;
        end
    end

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_dir  <= i_cmd.res_moved ? r_best_dir : DIR_UP;
            r_res_stat <= i_cmd.res_stat;
            r_res_last <= i_cmd.res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_dir  <= r_res_dir;
            r_out_stat <= r_res_stat;
            r_out_row  <= r_robot_row[COORD_W-1:0];
            r_out_col  <= r_robot_col[COORD_W-1:0];
            r_out_last <= r_res_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {(M_DATA_W - DIR_W - STAT_W - 2 * COORD_W)'(0),
                         r_out_col, r_out_row, r_out_stat, r_out_dir};

    // status to the controller
    assign o_stat.in_plan    = (i_s_tuser == CMD_PLAN);
    assign o_stat.cnt_last   = (r_row == LAST_RC) && (r_col == LAST_RC);
    assign o_stat.start_bad  = !r_tgt_ok || r_wall_rd;
    assign o_stat.goal_out   = (goal_row_x > LAST_RC) || (goal_col_x > LAST_RC);
    assign o_stat.at_goal    = (r_robot_row == goal_row_x) && (r_robot_col == goal_col_x);
    assign o_stat.sweep_zero = (r_limit == '0);
    assign o_stat.sweep_last = (r_sweep == r_limit - SWEEP_W'(1));
    assign o_stat.self_skip  = r_wave_rd inside {WAVE_WALL, WAVE_GOAL};
    assign o_stat.self_robot = (r_self == WAVE_ROBOT);
    assign o_stat.best_ok    = (r_best < WAVE_LIMIT);
    assign o_stat.best_set   = (r_best != WAVE_LIMIT);
    assign o_stat.move_goal  = (nxt_row == goal_row_x) && (nxt_col == goal_col_x);
    assign o_stat.move_cap   = (r_moves == LAST_MOVE);
    assign o_stat.out_free   = !r_out_valid || i_m_tready;
    assign o_stat.res_last   = r_res_last;

endmodule

/* design/grid_wavefront_path_planner_core.sv */
// Top level of the grid wavefront path planner: controller plus datapath.
// Depends on gwp_pkg, gwp_ctrl and gwp_datapath.
//
//  channel   direction  ports                         beat contents
//  -------   ---------  ----------------------------  ---------------------------------
//  s (in)    sink       i_s_tvalid/o_s_tready         tuser: command; tdata: map cell
//  m (out)   source     o_m_tvalid/i_m_tready         tdata: one move; tlast: run end
//  cfg       sink       i_cfg_valid/o_cfg_ready       index 0 goal_row, 1 goal_col,
//                                                     2 sweep_limit
//
//  A map write beat goes straight into the wall map. A plan beat runs the start checks,
//  then per move rebuilds the wave map and makes at most sweep_limit raster sweeps; each
//  open cell is read with its four neighbors in turn through the one wave map read port.
//  After reset the wall map is cleared cell by cell, during which no beat is taken.
//  A held output beat stalls the planner only when the next result is ready to load.
module grid_wavefront_path_planner_core #(
    parameter int GRID_SIZE = gwp_pkg::GRID_SIZE_DEF,
    parameter int MAX_MOVES = gwp_pkg::MAX_MOVES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [2:0] target_row, [5:3] target_col, [6] is_wall, [7] zero
    input  logic [gwp_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [0] command
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [1:0] move_dir, [3:2] status, [6:4] robot_row, [9:7] robot_col, [15:10] zero
    output logic [gwp_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gwp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gwp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gwp_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    gwp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gwp_datapath #(
        .GRID_SIZE (GRID_SIZE),
        .MAX_MOVES (MAX_MOVES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

/* test/tb.sv */
// Self-checking testbench for grid_wavefront_path_planner_core: map writes and plan runs
// go in over the stream port, every move coming out is checked against a wavefront predictor.
// Depends on gwp_pkg and the core; runs on its own.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gwp_pkg::*;

    localparam int G           = GRID_SIZE_DEF;
    localparam int CELLS       = G * G;
    localparam int MOVE_CAP    = MAX_MOVES_DEF;
    localparam int NO_STEP     = 4;
    localparam int HOLD_CYCLES = 3000;
    localparam int RAND_BEATS  = 22;

    typedef struct {
        t_dir         dir;
        t_status      stat;
        logic [2:0]   row;
        logic [2:0]   col;
        logic         last;
    } t_move;

    // Wavefront predictor plus the queue of moves still owed by the block
    class t_plan_ledger;
        bit           walls[CELLS];
        logic [7:0]   wave[CELLS];
        logic [2:0]   bot_row;
        logic [2:0]   bot_col;
        logic [2:0]   goal_r;
        logic [2:0]   goal_c;
        logic [7:0]   sweep_cap;
        t_move        owed_moves[$];
        int           errors;
        int           beats;
        int           plans;
        int           results_seen;
        int           by_status[4];
        longint       cycle_budget;

        function new();
            foreach (walls[i]) walls[i] = 1'b0;
            foreach (wave[i]) wave[i] = '0;
            foreach (by_status[i]) by_status[i] = 0;
            bot_row = '0;
            bot_col = '0;
            goal_r = GOAL_ROW_RST;
            goal_c = GOAL_COL_RST;
            sweep_cap = SWEEP_LIMIT_RST;
            errors = 0;
            beats = 0;
            plans = 0;
            results_seen = 0;
            cycle_budget = 300000;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [7:0] val);
            case (idx)
                CFG_GOAL_ROW:    goal_r = val[2:0];
                CFG_GOAL_COL:    goal_c = val[2:0];
                CFG_SWEEP_LIMIT: sweep_cap = val;
                default: ;
            endcase
        endfunction

        // smallest usable neighbor; on ties the first of down, up, right, left wins
        function int best_neighbor(int r, int c, output int dir);
            int best;
            int v;
            best = WAVE_LIMIT;
            dir = NO_STEP;
            if (r + 1 < G) begin
                v = wave[(r + 1) * G + c];
                if (v != 0 && v < best) begin best = v; dir = DIR_DOWN; end
            end
            if (r > 0) begin
                v = wave[(r - 1) * G + c];
                if (v != 0 && v < best) begin best = v; dir = DIR_UP; end
            end
            if (c + 1 < G) begin
                v = wave[r * G + c + 1];
                if (v != 0 && v < best) begin best = v; dir = DIR_RIGHT; end
            end
            if (c > 0) begin
                v = wave[r * G + c - 1];
                if (v != 0 && v < best) begin best = v; dir = DIR_LEFT; end
            end
            return best;
        endfunction

        // rebuild the wave map and sweep in place until the robot sees a way out or sweep_cap runs out
        function int next_step(output int sweeps);
            int idx;
            int m;
            int d;
            foreach (wave[i]) wave[i] = walls[i] ? WAVE_WALL : 8'd0;
            wave[goal_r * G + goal_c] = WAVE_GOAL;
            wave[bot_row * G + bot_col] = WAVE_ROBOT;
            sweeps = 0;
            for (int s = 0; s < sweep_cap; s++) begin
                sweeps = s + 1;
                for (int r = 0; r < G; r++) begin
                    for (int c = 0; c < G; c++) begin
                        idx = r * G + c;
                        if (wave[idx] == WAVE_WALL || wave[idx] == WAVE_GOAL) continue;
                        m = best_neighbor(r, c, d);
                        if (wave[idx] == WAVE_ROBOT) begin
                            if (m < WAVE_LIMIT) return d;
                        end else if (m != WAVE_LIMIT) begin
                            wave[idx] = 8'(m + 1);
                        end
                    end
                end
            end
            return NO_STEP;
        endfunction

        function void owe(t_dir d, t_status st, logic last);
            t_move e;
            e.dir = d;
            e.stat = st;
            e.row = bot_row;
            e.col = bot_col;
            e.last = last;
            by_status[st]++;
            owed_moves.push_back(e);
        endfunction

        function void note_beat(logic cmd, logic [2:0] row, logic [2:0] col, logic wall);
            int d;
            int sweeps;
            longint cost;
            int first_new;
            beats++;
            cycle_budget += 1000;
            if (cmd == CMD_WRITE) begin
                if (row < G && col < G) walls[row * G + col] = wall;
                return;
            end
            plans++;
            first_new = owed_moves.size();
            cost = 4;
            if (row >= G || col >= G || walls[row * G + col]) begin
                owe(DIR_UP, ST_REJECT, 1'b1);
            end else begin
                bot_row = row;
                bot_col = col;
                if (goal_r >= G || goal_c >= G) begin
                    owe(DIR_UP, ST_NO_PATH, 1'b1);
                end else if (row == goal_r && col == goal_c) begin
                    owe(DIR_UP, ST_ARRIVED, 1'b1);
                end else begin
                    for (int k = 0; k < MOVE_CAP; k++) begin
                        d = next_step(sweeps);
                        cost += 2 * CELLS + 7 * CELLS * sweeps + 16;
                        if (d == NO_STEP) begin
                            owe(DIR_UP, ST_NO_PATH, 1'b1);
                            break;
                        end
                        case (d)
                            DIR_UP:    bot_row--;
                            DIR_RIGHT: bot_col++;
                            DIR_DOWN:  bot_row++;
                            default:   bot_col--;
                        endcase
                        if (bot_row == goal_r && bot_col == goal_c) begin
                            owe(t_dir'(d), ST_ARRIVED, 1'b1);
                            break;
                        end
                        if (k == MOVE_CAP - 1) begin
                            owe(t_dir'(d), ST_REJECT, 1'b1);
                            break;
                        end
                        owe(t_dir'(d), ST_MOVED, 1'b0);
                    end
                end
            end
            cycle_budget += 4 * cost + 200 * (owed_moves.size() - first_new);
        endfunction

        task flag(string msg);
            errors++;
            if (errors <= 20) $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [M_DATA_W-1:0] data, logic last);
            t_move e;
            results_seen++;
            if (owed_moves.size() == 0) begin
                flag($sformatf("result %0d with nothing owed: tdata %h tlast %0d",
                               results_seen, data, last));
                return;
            end
            e = owed_moves.pop_front();
            if (data[1:0] !== e.dir || data[3:2] !== e.stat || data[6:4] !== e.row ||
                data[9:7] !== e.col || last !== e.last)
                flag($sformatf({"result %0d: got dir %0d stat %0d at (%0d,%0d) last %0d, ",
                                "want dir %0d stat %0d at (%0d,%0d) last %0d"},
                               results_seen, data[1:0], data[3:2], data[6:4], data[9:7], last,
                               e.dir, e.stat, e.row, e.col, e.last));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_plan_ledger ledger;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         hold_asked = 0;
    int         hold_done = 0;
    int         hold_left = 0;

    grid_wavefront_path_planner_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // move receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_done) begin
            hold_done <= hold_asked;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) ledger.check_result(o_m_tdata, o_m_tlast);
            if (i_s_tvalid && o_s_tready)
                ledger.note_beat(i_s_tuser, i_s_tdata[2:0], i_s_tdata[5:3], i_s_tdata[6]);
        end
    end

    initial begin : watchdog
        longint n;
        n = 0;
        @(posedge i_clk);
        while (n < ledger.cycle_budget) begin
            @(posedge i_clk);
            n++;
        end
        $display("tb: errors");
        $finish;
    end

    // hold valid high after the beat so a following beat can go back to back
    task send_beat(t_cmd_code cmd, logic [2:0] row, logic [2:0] col, logic wall);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {1'b0, wall, col, row};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task configure(logic [2:0] goal_row, logic [2:0] goal_col, logic [7:0] sweeps);
        logic [7:0] vals[3];
        t_cfg_reg   idx;
        vals[0] = goal_row;
        vals[1] = goal_col;
        vals[2] = sweeps;
        for (int i = 0; i < 3; i++) begin
            idx = t_cfg_reg'(i);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            ledger.set_reg(idx, vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // drop valid, wait for every owed move, then let a trailing map write finish
    task settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (ledger.owed_moves.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task random_beat(int phase);
        logic [2:0] r;
        logic [2:0] c;
        int         tries;
        if ($urandom_range(99) < 60) begin
            if ($urandom_range(9) == 0) begin
                r = 3'($urandom_range(7));
                c = 3'($urandom_range(7));
            end else begin
                tries = 0;
                do begin
                    r = 3'($urandom_range(G - 1));
                    c = 3'($urandom_range(G - 1));
                    tries++;
                end while (ledger.walls[r * G + c] && tries < 8);
            end
            send_beat(CMD_PLAN, r, c, 1'($urandom_range(1)));
        end else begin
            if ($urandom_range(9) == 0) begin
                r = 3'($urandom_range(7));
                c = 3'($urandom_range(7));
            end else begin
                r = 3'($urandom_range(G - 1));
                c = 3'($urandom_range(G - 1));
            end
            // keep the map sparse in the long-sweep phase
            send_beat(CMD_WRITE, r, c, $urandom_range(99) < (phase == 1 ? 10 : 25));
        end
    endtask

    initial begin
        int caps[4];
        int gaps[4];
        int stalls[4];
        ledger = new();
        caps = '{50, 255, 12, 50};
        gaps = '{0, 50, 0, 26};
        stalls = '{0, 0, 50, 26};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corner cases under reset settings, then under edge settings
        send_beat(CMD_PLAN, 0, 3, 0);
        send_beat(CMD_PLAN, 5, 0, 1);
        send_beat(CMD_WRITE, 6, 2, 1);
        send_beat(CMD_WRITE, 2, 7, 1);
        send_beat(CMD_WRITE, 4, 4, 1);
        send_beat(CMD_PLAN, 4, 4, 0);
        send_beat(CMD_PLAN, 7, 5, 0);
        // wall the goal in on three sides
        send_beat(CMD_WRITE, 0, 2, 1);
        send_beat(CMD_WRITE, 1, 3, 1);
        send_beat(CMD_WRITE, 0, 4, 1);
        send_beat(CMD_PLAN, 5, 5, 0);
        settle();
        configure(0, 3, 255);
        send_beat(CMD_PLAN, 3, 0, 0);
        send_beat(CMD_WRITE, 1, 3, 0);
        settle();
        configure(5, 5, 1);
        send_beat(CMD_PLAN, 0, 0, 0);
        settle();
        configure(7, 3, 50);
        send_beat(CMD_PLAN, 2, 2, 0);
        settle();
        configure(5, 0, 0);
        send_beat(CMD_PLAN, 1, 1, 0);
        settle();
        // goal sits on a wall cell
        configure(5, 0, 50);
        send_beat(CMD_WRITE, 5, 0, 1);
        send_beat(CMD_PLAN, 0, 5, 0);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            configure(3'($urandom_range(G - 1)), 3'($urandom_range(G - 1)), 8'(caps[phase]));
            gap_pct = gaps[phase];
            stall_pct = stalls[phase];
            if (phase == 0) hold_asked++;
            repeat (RAND_BEATS) random_beat(phase);
            settle();
        end
        gap_pct = 0;
        stall_pct = 0;
        repeat (100) @(posedge i_clk);

        $display("summary: %0d beats in, %0d plan runs, %0d moves checked", ledger.beats,
                 ledger.plans, ledger.results_seen);
        $display("summary: %0d moved, %0d arrived, %0d no path, %0d rejected or capped",
                 ledger.by_status[ST_MOVED], ledger.by_status[ST_ARRIVED],
                 ledger.by_status[ST_NO_PATH], ledger.by_status[ST_REJECT]);
        if (ledger.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
